[hw/rtl/kev_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kev_pkg
// Shared codes, defaults and the command bundle of the key event table.
// ----------------------------------------------------------------------------
package kev_pkg;

    localparam int ENTRIES_DEF   = 16;
    localparam int KEY_COUNT_DEF = 64;
    localparam int MAX_RESULTS   = 16;

    localparam logic [2:0] FUNC_TICK       = 3'd0;
    localparam logic [2:0] FUNC_REGISTER   = 3'd1;
    localparam logic [2:0] FUNC_REMOVE_ID  = 3'd2;
    localparam logic [2:0] FUNC_REMOVE_KEY = 3'd3;
    localparam logic [2:0] FUNC_CLEAR      = 3'd4;

    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_HOLD    = 2'd2;

    localparam logic [1:0] EV_PRESS   = 2'd0;
    localparam logic [1:0] EV_RELEASE = 2'd1;
    localparam logic [1:0] EV_HOLD    = 2'd2;
    localparam logic [1:0] EV_NONE    = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [23:0] HOLD_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic finish;
    } kev_cmd_t;

endpackage

[hw/rtl/key_event_table_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_event_table_core
// Watch table for key press, release and hold events with auto-repeat.
// ----------------------------------------------------------------------------
// Every item is one pass: the sequencer walks one slot per cycle through the
// slot memory read port, then closes the item.
// Tick events appear during the walk, the final beat at the end; busy stays
// high until the final beat is issued. Results cannot be stalled.
// Reset clears all slots, flags and the id counter (next id is one).
// ----------------------------------------------------------------------------
module key_event_table_core #(
    parameter int ENTRIES   = kev_pkg::ENTRIES_DEF,
    parameter int KEY_COUNT = kev_pkg::KEY_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [31:0] now_ms,
    input  logic [63:0] pressed_map,
    input  logic [5:0]  key,
    input  logic [1:0]  kind,
    input  logic [15:0] hold_delay_ms,
    input  logic        repeat_enable,
    input  logic [15:0] repeat_period_ms,
    input  logic [15:0] target_id,
    output logic        result_valid,
    output logic [1:0]  event_kind,
    output logic [15:0] entry_id,
    output logic [23:0] hold_ms,
    output logic [1:0]  status,
    output logic [6:0]  removed_count,
    output logic        last
);
    import kev_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    kev_cmd_t         cmd;
    logic [IDX_W-1:0] rd_addr;

    kev_ctrl #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .rd_addr (rd_addr)
    );

    kev_dp #(
        .ENTRIES   (ENTRIES),
        .KEY_COUNT (KEY_COUNT),
        .IDX_W     (IDX_W)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .rd_addr          (rd_addr),
        .func             (func),
        .now_ms           (now_ms),
        .pressed_map      (pressed_map),
        .key              (key),
        .kind             (kind),
        .hold_delay_ms    (hold_delay_ms),
        .repeat_enable    (repeat_enable),
        .repeat_period_ms (repeat_period_ms),
        .target_id        (target_id),
        .result_valid     (result_valid),
        .event_kind       (event_kind),
        .entry_id         (entry_id),
        .hold_ms          (hold_ms),
        .status           (status),
        .removed_count    (removed_count),
        .last             (last)
    );

endmodule

[hw/rtl/kev_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kev_ctrl
// Sequencer: accepts a beat, walks every slot once, then closes the item.
// ----------------------------------------------------------------------------
module kev_ctrl #(
    parameter int ENTRIES = kev_pkg::ENTRIES_DEF,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output kev_pkg::kev_cmd_t cmd,
    output logic [IDX_W-1:0]  rd_addr
);
    import kev_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_DRAIN, S_FINISH} state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_WALK;
                        idx_reg   <= '0;
                        busy_reg  <= 1'b1;
                    end
                end
                S_WALK:
                begin
                    if (idx_reg == IDX_W'(ENTRIES - 1))
                        state_reg <= S_DRAIN;
                    else
                        idx_reg <= idx_reg + IDX_W'(1);
                end
                S_DRAIN:
                    state_reg <= S_FINISH;
                S_FINISH:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy       = busy_reg;
    assign rd_addr    = idx_reg;
    assign cmd.load   = (state_reg == S_IDLE) && start;
    assign cmd.rd_en  = (state_reg == S_WALK);
    assign cmd.finish = (state_reg == S_FINISH);

endmodule

[hw/rtl/kev_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kev_dp
// Slot storage, per-slot evaluation, event buffering and result registers.
// ----------------------------------------------------------------------------
module kev_dp #(
    parameter int ENTRIES   = kev_pkg::ENTRIES_DEF,
    parameter int KEY_COUNT = kev_pkg::KEY_COUNT_DEF,
    parameter int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  kev_pkg::kev_cmd_t cmd,
    input  logic [IDX_W-1:0]  rd_addr,
    input  logic [2:0]        func,
    input  logic [31:0]       now_ms,
    input  logic [63:0]       pressed_map,
    input  logic [5:0]        key,
    input  logic [1:0]        kind,
    input  logic [15:0]       hold_delay_ms,
    input  logic              repeat_enable,
    input  logic [15:0]       repeat_period_ms,
    input  logic [15:0]       target_id,
    output logic              result_valid,
    output logic [1:0]        event_kind,
    output logic [15:0]       entry_id,
    output logic [23:0]       hold_ms,
    output logic [1:0]        status,
    output logic [6:0]        removed_count,
    output logic              last
);
    import kev_pkg::*;

    // latched item
    logic [2:0]  func_reg;
    logic [31:0] now_reg;
    logic [63:0] map_reg;
    logic [5:0]  key_reg;
    logic [1:0]  kind_reg;
    logic [15:0] delay_reg;
    logic        rep_reg;
    logic [15:0] intv_reg;
    logic [15:0] target_reg;

    // slot memories
    logic [15:0] mem_id    [ENTRIES];
    logic [5:0]  mem_key   [ENTRIES];
    logic [1:0]  mem_kind  [ENTRIES];
    logic [15:0] mem_delay [ENTRIES];
    logic        mem_rep   [ENTRIES];
    logic [15:0] mem_intv  [ENTRIES];
    logic [31:0] mem_press [ENTRIES];
    logic [31:0] mem_last  [ENTRIES];

    logic [15:0] rd_id_reg;
    logic [5:0]  rd_key_reg;
    logic [1:0]  rd_kind_reg;
    logic [15:0] rd_delay_reg;
    logic        rd_rep_reg;
    logic [15:0] rd_intv_reg;
    logic [31:0] rd_press_reg;
    logic [31:0] rd_last_reg;

    logic             p_vld_reg;
    logic [IDX_W-1:0] p_idx_reg;

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] was_down_reg;
    logic [ENTRIES-1:0] fired_reg;
    logic [15:0]        next_id_reg;
    logic               found_reg;
    logic [15:0]        ans_id_reg;
    logic [6:0]         cnt_reg;
    logic [4:0]         n_reg;

    logic               pend_vld_reg;
    logic [1:0]         pend_ev_reg;
    logic [15:0]        pend_id_reg;
    logic [23:0]        pend_hold_reg;

    logic               res_vld_reg;
    logic [1:0]         res_ev_reg;
    logic [15:0]        res_id_reg;
    logic [23:0]        res_hold_reg;
    logic [1:0]         res_st_reg;
    logic [6:0]         res_cnt_reg;
    logic               res_last_reg;

    // per-slot evaluation
    logic        cur_valid;
    logic        wd;
    logic        down;
    logic        press_edge;
    logic [31:0] pt;
    logic        hf;
    logic [31:0] elapsed;
    logic        fire;
    logic [1:0]  ev;
    logic [23:0] hold_val;
    logic        hf_new;
    logic        do_tick;
    logic        do_reg;
    logic        do_rm_id;
    logic        do_rm_key;
    logic        emit;

    always_comb
    begin
        cur_valid  = valid_reg[p_idx_reg];
        wd         = was_down_reg[p_idx_reg];
        down       = ({1'b0, rd_key_reg} < 7'(KEY_COUNT)) && map_reg[rd_key_reg];
        press_edge = down && !wd;
        pt         = press_edge ? now_reg : rd_press_reg;
        hf         = press_edge ? 1'b0 : fired_reg[p_idx_reg];
        elapsed    = now_reg - pt;
        fire       = 1'b0;
        ev         = EV_NONE;
        hold_val   = '0;
        hf_new     = hf;
        case (rd_kind_reg)
            KIND_PRESS:
            begin
                fire = down && !wd;
                ev   = EV_PRESS;
            end
            KIND_RELEASE:
            begin
                fire = !down && wd;
                ev   = EV_RELEASE;
            end
            KIND_HOLD:
            begin
                ev = EV_HOLD;
                if (down && (elapsed >= {16'd0, rd_delay_reg}) &&
                    (!hf || (rd_rep_reg && ((now_reg - rd_last_reg) >= {16'd0, rd_intv_reg}))))
                begin
                    fire   = 1'b1;
                    hf_new = 1'b1;
                end
                hold_val = (|elapsed[31:24]) ? HOLD_MAX : elapsed[23:0];
            end
            default:
                fire = 1'b0;
        endcase
        do_tick   = p_vld_reg && cur_valid && (func_reg == FUNC_TICK);
        do_reg    = p_vld_reg && !cur_valid && !found_reg && (func_reg == FUNC_REGISTER);
        do_rm_id  = p_vld_reg && cur_valid && !found_reg && (func_reg == FUNC_REMOVE_ID) &&
                    (rd_id_reg == target_reg);
        do_rm_key = p_vld_reg && cur_valid && (func_reg == FUNC_REMOVE_KEY) &&
                    (rd_key_reg == key_reg);
        emit      = do_tick && fire && (n_reg < 5'(MAX_RESULTS));
    end

    // item latch, memories, read port
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= func;
            now_reg    <= now_ms;
            map_reg    <= pressed_map;
            key_reg    <= key;
            kind_reg   <= kind;
            delay_reg  <= hold_delay_ms;
            rep_reg    <= repeat_enable;
            intv_reg   <= repeat_period_ms;
            target_reg <= target_id;
        end
        if (cmd.rd_en)
        begin
            rd_id_reg    <= mem_id[rd_addr];
            rd_key_reg   <= mem_key[rd_addr];
            rd_kind_reg  <= mem_kind[rd_addr];
            rd_delay_reg <= mem_delay[rd_addr];
            rd_rep_reg   <= mem_rep[rd_addr];
            rd_intv_reg  <= mem_intv[rd_addr];
            rd_press_reg <= mem_press[rd_addr];
            rd_last_reg  <= mem_last[rd_addr];
        end
        if (do_reg)
        begin
            mem_id[p_idx_reg]    <= next_id_reg;
            mem_key[p_idx_reg]   <= key_reg;
            mem_kind[p_idx_reg]  <= kind_reg;
            mem_delay[p_idx_reg] <= delay_reg;
            mem_rep[p_idx_reg]   <= rep_reg;
            mem_intv[p_idx_reg]  <= intv_reg;
        end
        if (do_tick && (rd_kind_reg == KIND_HOLD))
        begin
            if (press_edge)
                mem_press[p_idx_reg] <= now_reg;
            if (fire)
                mem_last[p_idx_reg] <= now_reg;
        end
        if (do_reg)
            ans_id_reg <= next_id_reg;
        if (emit)
        begin
            pend_ev_reg   <= ev;
            pend_id_reg   <= rd_id_reg;
            pend_hold_reg <= (ev == EV_HOLD) ? hold_val : 24'd0;
        end
    end

    // control state and results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg    <= 1'b0;
            p_idx_reg    <= '0;
            valid_reg    <= '0;
            was_down_reg <= '0;
            fired_reg    <= '0;
            next_id_reg  <= 16'd1;
            found_reg    <= 1'b0;
            cnt_reg      <= '0;
            n_reg        <= '0;
            pend_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
            res_ev_reg   <= EV_NONE;
            res_id_reg   <= '0;
            res_hold_reg <= '0;
            res_st_reg   <= ST_OK;
            res_cnt_reg  <= '0;
            res_last_reg <= 1'b0;
        end
        else
        begin
            p_vld_reg   <= cmd.rd_en;
            p_idx_reg   <= rd_addr;
            res_vld_reg <= 1'b0;
            if (cmd.load)
            begin
                found_reg    <= 1'b0;
                cnt_reg      <= '0;
                n_reg        <= '0;
                pend_vld_reg <= 1'b0;
            end
            if (do_tick)
            begin
                was_down_reg[p_idx_reg] <= down;
                if (rd_kind_reg == KIND_HOLD)
                    fired_reg[p_idx_reg] <= hf_new;
            end
            if (do_reg)
            begin
                valid_reg[p_idx_reg]    <= 1'b1;
                was_down_reg[p_idx_reg] <= 1'b0;
                fired_reg[p_idx_reg]    <= 1'b0;
                next_id_reg             <= next_id_reg + 16'd1;
                found_reg               <= 1'b1;
            end
            if (do_rm_id)
            begin
                valid_reg[p_idx_reg] <= 1'b0;
                found_reg            <= 1'b1;
            end
            if (do_rm_key)
            begin
                valid_reg[p_idx_reg] <= 1'b0;
                cnt_reg              <= cnt_reg + 7'd1;
            end
            if (emit)
            begin
                // flush the held beat: a newer event follows it
                n_reg        <= n_reg + 5'd1;
                pend_vld_reg <= 1'b1;
                if (pend_vld_reg)
                begin
                    res_vld_reg  <= 1'b1;
                    res_ev_reg   <= pend_ev_reg;
                    res_id_reg   <= pend_id_reg;
                    res_hold_reg <= pend_hold_reg;
                    res_st_reg   <= ST_OK;
                    res_cnt_reg  <= '0;
                    res_last_reg <= 1'b0;
                end
            end
            if (cmd.finish)
            begin
                res_vld_reg  <= 1'b1;
                res_ev_reg   <= EV_NONE;
                res_id_reg   <= '0;
                res_hold_reg <= '0;
                res_st_reg   <= ST_OK;
                res_cnt_reg  <= '0;
                res_last_reg <= 1'b1;
                case (func_reg)
                    FUNC_TICK:
                    begin
                        if (pend_vld_reg)
                        begin
                            res_ev_reg   <= pend_ev_reg;
                            res_id_reg   <= pend_id_reg;
                            res_hold_reg <= pend_hold_reg;
                        end
                    end
                    FUNC_REGISTER:
                    begin
                        if (found_reg)
                            res_id_reg <= ans_id_reg;
                        else
                            res_st_reg <= ST_FULL;
                    end
                    FUNC_REMOVE_ID:
                    begin
                        res_id_reg <= target_reg;
                        res_st_reg <= found_reg ? ST_OK : ST_NOT_FOUND;
                    end
                    FUNC_REMOVE_KEY:
                        res_cnt_reg <= cnt_reg;
                    FUNC_CLEAR:
                        valid_reg <= '0;
                    default:
                        res_st_reg <= ST_OK;
                endcase
            end
        end
    end

    assign result_valid  = res_vld_reg;
    assign event_kind    = res_ev_reg;
    assign entry_id      = res_id_reg;
    assign hold_ms       = res_hold_reg;
    assign status        = res_st_reg;
    assign removed_count = res_cnt_reg;
    assign last          = res_last_reg;

endmodule
